[design/net_pkg.sv]
// Shared types and constants for the note envelope trigger.
`timescale 1ns / 1ps
`default_nettype none

package net_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_VOLUME       = 2'd0;
  localparam logic [1:0] REG_TEMPO_BPM    = 2'd1;
  localparam logic [1:0] REG_SCORE_LENGTH = 2'd2;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int LEN_W      = 9;
  // Sum of up to 511 durations of 16 bits.
  localparam int SUM_W      = 25;
  localparam int PROD_W     = SUM_W + 16;
  // Width of the shared divider: holds 60000 * sum / 256.
  localparam int DIV_W      = PROD_W - 8;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

  // Datapath actions of one microprogram step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SET_PTR,
    OP_NOTE_START,
    OP_TIE_ADD,
    OP_MUL,
    OP_DIV_LEN,
    OP_LOAD_LEN,
    OP_DIV_DEC,
    OP_LOAD_DEC,
    OP_DECAY_VOL,
    OP_REST,
    OP_EMIT,
    OP_WRITE
  } op_t;

  // Jump conditions tested by the sequencer.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_IS_LOAD,
    C_OUT_RANGE,
    C_PITCH_NOT_POS,
    C_PTR_END,
    C_NOT_TIE,
    C_DIV_BUSY,
    C_LEN_ZERO,
    C_PITCH_NONZERO,
    C_OUT_BUSY
  } cond_t;

  // Microprogram addresses.
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_RANGE,
    S_HEAD,
    S_NOTE,
    S_WALK_WAIT,
    S_WALK_TEST,
    S_WALK_ADD,
    S_MUL,
    S_DIV_LEN,
    S_WAIT_LEN,
    S_LOAD_LEN,
    S_LEN_CHK,
    S_DIV_DEC,
    S_WAIT_DEC,
    S_LOAD_DEC,
    S_DEC_ZERO,
    S_REST_CHK,
    S_REST,
    S_EMIT,
    S_DONE,
    S_WRITE
  } step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_input;
    logic is_load;
    logic out_range;
    logic pitch_not_pos;
    logic ptr_end;
    logic not_tie;
    logic div_busy;
    logic len_zero;
    logic pitch_nonzero;
    logic out_busy;
  } cond_flags_t;

endpackage

`default_nettype wire

[design/net_divider.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module net_divider
  import net_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  busy,
  output logic      [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       diff;
  logic                 ge;

  always_comb begin
    rem_sh = {rem, quo[DIV_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    ge     = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign quotient = quo;

  // A new division is only started once the previous one has finished.
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not go busy after start");

endmodule

`default_nettype wire

[design/net_sequencer.sv]
// Microprogram store and step counter with conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module net_sequencer
  import net_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cond_flags_t flags,
  output ctrl_word_t       ctrl
);

  step_t upc;
  step_t upc_next;
  logic  take;

  function automatic ctrl_word_t ucode(input step_t s);
    ctrl_word_t w;
    case (s)
      S_IDLE:      w = '{OP_ACCEPT,     C_NO_INPUT,      S_IDLE};
      S_DECODE:    w = '{OP_SET_PTR,    C_IS_LOAD,       S_WRITE};
      S_RANGE:     w = '{OP_NONE,       C_OUT_RANGE,     S_EMIT};
      S_HEAD:      w = '{OP_NONE,       C_PITCH_NOT_POS, S_REST_CHK};
      S_NOTE:      w = '{OP_NOTE_START, C_NONE,          S_IDLE};
      S_WALK_WAIT: w = '{OP_NONE,       C_PTR_END,       S_MUL};
      S_WALK_TEST: w = '{OP_NONE,       C_NOT_TIE,       S_MUL};
      S_WALK_ADD:  w = '{OP_TIE_ADD,    C_ALWAYS,        S_WALK_WAIT};
      S_MUL:       w = '{OP_MUL,        C_NONE,          S_IDLE};
      S_DIV_LEN:   w = '{OP_DIV_LEN,    C_NONE,          S_IDLE};
      S_WAIT_LEN:  w = '{OP_NONE,       C_DIV_BUSY,      S_WAIT_LEN};
      S_LOAD_LEN:  w = '{OP_LOAD_LEN,   C_NONE,          S_IDLE};
      S_LEN_CHK:   w = '{OP_NONE,       C_LEN_ZERO,      S_DEC_ZERO};
      S_DIV_DEC:   w = '{OP_DIV_DEC,    C_NONE,          S_IDLE};
      S_WAIT_DEC:  w = '{OP_NONE,       C_DIV_BUSY,      S_WAIT_DEC};
      S_LOAD_DEC:  w = '{OP_LOAD_DEC,   C_ALWAYS,        S_EMIT};
      S_DEC_ZERO:  w = '{OP_DECAY_VOL,  C_ALWAYS,        S_EMIT};
      S_REST_CHK:  w = '{OP_NONE,       C_PITCH_NONZERO, S_EMIT};
      S_REST:      w = '{OP_REST,       C_NONE,          S_IDLE};
      S_EMIT:      w = '{OP_EMIT,       C_OUT_BUSY,      S_EMIT};
      S_DONE:      w = '{OP_NONE,       C_ALWAYS,        S_IDLE};
      S_WRITE:     w = '{OP_WRITE,      C_ALWAYS,        S_IDLE};
      default:     w = '{OP_NONE,       C_ALWAYS,        S_IDLE};
    endcase
    return w;
  endfunction

  // Control word output.
  always_comb begin
    ctrl = ucode(upc);
  end

  // Next step: jump when the selected condition holds, else fall through.
  always_comb begin
    case (ctrl.cond)
      C_NONE:          take = 1'b0;
      C_ALWAYS:        take = 1'b1;
      C_NO_INPUT:      take = flags.no_input;
      C_IS_LOAD:       take = flags.is_load;
      C_OUT_RANGE:     take = flags.out_range;
      C_PITCH_NOT_POS: take = flags.pitch_not_pos;
      C_PTR_END:       take = flags.ptr_end;
      C_NOT_TIE:       take = flags.not_tie;
      C_DIV_BUSY:      take = flags.div_busy;
      C_LEN_ZERO:      take = flags.len_zero;
      C_PITCH_NONZERO: take = flags.pitch_nonzero;
      C_OUT_BUSY:      take = flags.out_busy;
      default:         take = 1'b0;
    endcase
    upc_next = take ? ctrl.target : step_t'(upc + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

[design/note_envelope_trigger.sv]
// Top level: score table, note envelope datapath and stream ports.
// A load transaction produces no result. A trigger on a note sums the beats of the ties after
// it and runs two divider passes, the note length and the decay; a zero note length skips the
// decay pass. Rests and out-of-range steps skip the divider; the next transaction is taken
// once a result has loaded. Reset clears the envelope and the output valid, and restores the
// configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module note_envelope_trigger
  import net_pkg::*;
#(
  parameter int SCORE_DEPTH        = 256,
  parameter int UPDATE_INTERVAL_MS = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input stream.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // entry_index[7:0], note_pitch[15:8], note_beats[31:16], step_position[41:32], zeros
  input  wire logic [47:0]           s_tdata,
  // req_type[0]
  input  wire logic                  s_tuser,
  // Output stream.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // brightness[7:0], hue[15:8], decay_rate[31:16]
  output logic      [31:0]           m_tdata,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW        = (SCORE_DEPTH > 1) ? $clog2(SCORE_DEPTH) : 1;
  localparam int PTR_W     = (AW > LEN_W) ? AW : LEN_W;
  localparam int DEPTH_CAP = (SCORE_DEPTH > 511) ? 511 : SCORE_DEPTH;

  // Hue by pitch class. The class is found with a reciprocal multiply:
  // floor(p * 43 / 512) equals floor(p / 12) for every 7-bit pitch.
  function automatic logic [7:0] hue_of_pitch(input logic [6:0] p);
    logic [12:0] scaled;
    logic [3:0]  q;
    logic [6:0]  r;
    logic [7:0]  h;
    scaled = 13'(p) * 13'd43;
    q      = scaled[12:9];
    r      = p - 7'(q) * 7'd12;
    case (r[3:0])
      4'd0:    h = 8'd0;
      4'd2:    h = 8'd25;
      4'd4:    h = 8'd45;
      4'd5:    h = 8'd85;
      4'd7:    h = 8'd130;
      4'd9:    h = 8'd170;
      4'd11:   h = 8'd215;
      default: h = 8'd0;
    endcase
    return h;
  endfunction

  // Configuration registers.
  logic [7:0]       volume;
  logic [9:0]       tempo_bpm;
  logic [LEN_W-1:0] score_length;

  // Captured transaction.
  logic             req_type;
  logic [7:0]       entry_index;
  logic [7:0]       note_pitch;
  logic [15:0]      note_beats;
  logic [9:0]       step_position;

  // Datapath registers.
  logic [PTR_W-1:0] ptr;
  logic [SUM_W-1:0] sum;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0] len_ms;
  logic [DIV_W-1:0] vnum;
  logic [7:0]       rd_pitch;
  logic [15:0]      rd_beats;

  // Envelope state.
  logic [7:0]       bright_now;
  logic [7:0]       hue_now;
  logic [15:0]      decay_now;

  // Score memory, no reset.
  logic [7:0]       pitch_mem [SCORE_DEPTH];
  logic [15:0]      beats_mem [SCORE_DEPTH];

  ctrl_word_t       ctrl;
  cond_flags_t      flags;
  logic [LEN_W-1:0] len;
  logic             in_fire;
  logic             out_busy;
  logic             write_ok;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_busy;
  logic [DIV_W-1:0] div_quotient;
  logic [9:0]       bpm_eff;

  // The score length is capped at the memory depth.
  assign len = (score_length > LEN_W'(DEPTH_CAP)) ? LEN_W'(DEPTH_CAP) : score_length;

  assign s_tready = (ctrl.op == OP_ACCEPT);
  assign in_fire  = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;
  assign write_ok = ({24'd0, entry_index} < 32'(SCORE_DEPTH));
  assign bpm_eff  = (tempo_bpm == 10'd0) ? 10'd1 : tempo_bpm;

  // Condition flags for the sequencer.
  always_comb begin
    flags.no_input      = !s_tvalid;
    flags.is_load       = !req_type;
    flags.out_range     = step_position[9] || (step_position[8:0] >= len);
    flags.pitch_not_pos = rd_pitch[7] || (rd_pitch == 8'd0);
    flags.ptr_end       = (ptr >= PTR_W'(len));
    flags.not_tie       = (rd_pitch != 8'hFF);
    flags.div_busy      = div_busy;
    flags.len_zero      = (len_ms == '0);
    flags.pitch_nonzero = (rd_pitch != 8'd0);
    flags.out_busy      = out_busy;
  end

  net_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // The divider serves two passes: the note length from the scaled beat sum and
  // the tempo, then the decay from the scaled volume and the note length.
  always_comb begin
    div_start    = (ctrl.op == OP_DIV_LEN) || (ctrl.op == OP_DIV_DEC);
    div_dividend = (ctrl.op == OP_DIV_LEN) ? prod[PROD_W-1:8] : vnum;
    div_divisor  = (ctrl.op == OP_DIV_LEN) ? DIV_W'(bpm_eff) : len_ms;
  end

  net_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      volume       <= 8'd255;
      tempo_bpm    <= 10'd120;
      score_length <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_VOLUME:       volume       <= cfg_wdata[7:0];
        REG_TEMPO_BPM:    tempo_bpm    <= cfg_wdata;
        REG_SCORE_LENGTH: score_length <= cfg_wdata[LEN_W-1:0];
        default:          ;
      endcase
    end
  end

  // Transaction capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type      <= s_tuser;
      entry_index   <= s_tdata[7:0];
      note_pitch    <= s_tdata[15:8];
      note_beats    <= s_tdata[31:16];
      step_position <= s_tdata[41:32];
    end
  end

  // Score memory: one write port, one registered read port at the walk pointer.
  always_ff @(posedge clk) begin
    if ((ctrl.op == OP_WRITE) && write_ok) begin
      pitch_mem[AW'(entry_index)] <= note_pitch;
      beats_mem[AW'(entry_index)] <= note_beats;
    end
    rd_pitch <= pitch_mem[ptr[AW-1:0]];
    rd_beats <= beats_mem[ptr[AW-1:0]];
  end

  // Walk pointer, beat sum, product and note length.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_SET_PTR:    ptr <= PTR_W'(step_position[8:0]);
      OP_NOTE_START: begin
        sum <= SUM_W'(rd_beats);
        ptr <= ptr + 1'b1;
      end
      OP_TIE_ADD:    begin
        sum <= sum + SUM_W'(rd_beats);
        ptr <= ptr + 1'b1;
      end
      OP_MUL:        prod <= PROD_W'(sum) * PROD_W'(MS_PER_MINUTE);
      OP_LOAD_LEN:   begin
        len_ms <= div_quotient;
        vnum   <= DIV_W'(32'(volume) * 32'(UPDATE_INTERVAL_MS)) << 8;
      end
      default:       ;
    endcase
  end

  // Envelope state: set at a note onset, cleared brightness on a rest.
  always_ff @(posedge clk) begin
    if (rst) begin
      bright_now <= 8'd0;
      hue_now    <= 8'd0;
      decay_now  <= 16'd0;
    end else begin
      case (ctrl.op)
        OP_NOTE_START: begin
          bright_now <= volume;
          hue_now    <= hue_of_pitch(rd_pitch[6:0]);
        end
        OP_LOAD_DEC:   begin
          decay_now <= (div_quotient > DIV_W'(16'hFFFF)) ? 16'hFFFF : div_quotient[15:0];
        end
        OP_DECAY_VOL:  decay_now  <= {volume, 8'd0};
        OP_REST:       bright_now <= 8'd0;
        default:       ;
      endcase
    end
  end

  // Output register: loaded once the previous result has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((ctrl.op == OP_EMIT) && !out_busy) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.op == OP_EMIT) && !out_busy) begin
      m_tdata <= {decay_now, hue_now, bright_now};
    end
  end

  // After a transaction is taken the sequencer leaves its idle step.
  assert property (@(posedge clk) disable iff (rst) in_fire |=> !s_tready)
    else $error("input accepted on two consecutive cycles");
  // A new result only appears from the emit step.
  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> $past(ctrl.op == OP_EMIT))
    else $error("result raised outside the emit step");
  // The tie walk never reads beyond the score length.
  assert property (@(posedge clk) disable iff (rst) (ctrl.op == OP_TIE_ADD) |-> (ptr < PTR_W'(len)))
    else $error("tie walk past the end of the score");

endmodule

`default_nettype wire

[tb/tb_note_envelope_trigger.sv]
// Self-checking testbench for the note envelope trigger: score loads, step triggers, checks.
`timescale 1ns / 1ps

module tb_note_envelope_trigger;
  import net_pkg::*;

  localparam int SCORE_ENTRIES = 256;
  localparam int UPDATE_MS     = 20;

  // Request kinds carried on s_tuser.
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_TRIGGER = 1'b1;

  // Pitch codes stored in the score.
  localparam logic [7:0] PITCH_TIE  = 8'hFF;
  localparam logic [7:0] PITCH_REST = 8'h00;

  // Run length in items, and safety margins in clock cycles.
  localparam int ITEM_TARGET   = 800;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 40;
  // The slowest trigger walks 255 ties, and the receiver may also stall the result;
  // the limit leaves a wide margin over that.
  localparam int STALL_LIMIT   = 5000;

  typedef struct {
    logic              kind;
    logic [7:0]        index;
    logic [7:0]        pitch;
    logic [15:0]       beats;
    logic signed [9:0] step;
  } score_req_t;

  typedef struct {
    logic [7:0]  brightness;
    logic [7:0]  hue;
    logic [15:0] decay;
  } envelope_t;

  // Mirrors the score table and the envelope registers, and keeps the envelopes that
  // the accepted triggers will report, oldest first.
  class envelope_scoreboard;
    logic [7:0]  pitch_tab[SCORE_ENTRIES];
    logic [15:0] beats_tab[SCORE_ENTRIES];
    logic [7:0]  level;
    logic [7:0]  hue_now;
    logic [15:0] decay_now;
    logic [7:0]  volume;
    logic [9:0]  tempo;
    logic [8:0]  score_count;
    envelope_t   due_envelopes[$];
    int          mismatches;

    function void reset_state();
      level       = '0;
      hue_now     = '0;
      decay_now   = '0;
      volume      = 8'd255;
      tempo       = 10'd120;
      score_count = '0;
      mismatches  = 0;
      due_envelopes.delete();
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_VOLUME:       volume = val[7:0];
        REG_TEMPO_BPM:    tempo = val;
        REG_SCORE_LENGTH: score_count = val[8:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_envelopes.size();
    endfunction

    function logic [7:0] hue_for_class(int pc);
      case (pc)
        2:       return 8'd25;
        4:       return 8'd45;
        5:       return 8'd85;
        7:       return 8'd130;
        9:       return 8'd170;
        11:      return 8'd215;
        default: return 8'd0;
      endcase
    endfunction

    // A note sets the level and hue and derives the decay from its length including the
    // ties after it; a rest only darkens; anything else leaves the envelope alone.
    function void fire_step(logic signed [9:0] step);
      int idx;
      int j;
      int len;
      int p;
      longint unsigned sum;
      longint unsigned bpm;
      longint unsigned len_ms;
      longint unsigned dec;
      len = (score_count > SCORE_ENTRIES) ? SCORE_ENTRIES : int'(score_count);
      if (step < 0 || int'(step) >= len) return;
      idx = step;
      p = $signed(pitch_tab[idx]);
      if (p > 0) begin
        sum = beats_tab[idx];
        bpm = (tempo == 0) ? 1 : tempo;
        level = volume;
        hue_now = hue_for_class(p % 12);
        for (j = idx + 1; j < len && pitch_tab[j] == PITCH_TIE; j++) begin
          sum += beats_tab[j];
        end
        len_ms = (60000 * sum) / (256 * bpm);
        if (len_ms == 0) begin
          dec = {volume, 8'h00};
        end else begin
          dec = (64'(volume) * UPDATE_MS * 256) / len_ms;
          if (dec > 65535) dec = 65535;
        end
        decay_now = dec[15:0];
      end else if (p == 0) begin
        level = '0;
      end
    endfunction

    function void note_input(score_req_t req);
      if (req.kind == REQ_LOAD) begin
        pitch_tab[req.index] = req.pitch;
        beats_tab[req.index] = req.beats;
      end else begin
        fire_step(req.step);
        due_envelopes.push_back('{level, hue_now, decay_now});
      end
    endfunction

    task flag(string msg);
      mismatches++;
      if (mismatches <= 20) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task check_result(logic [31:0] word);
      envelope_t want;
      if (due_envelopes.size() == 0) begin
        flag($sformatf("result %h arrived with nothing expected", word));
        return;
      end
      want = due_envelopes.pop_front();
      if (word[7:0] !== want.brightness)
        flag($sformatf("brightness %0d, expected %0d", word[7:0], want.brightness));
      if (word[15:8] !== want.hue)
        flag($sformatf("hue %0d, expected %0d", word[15:8], want.hue));
      if (word[31:16] !== want.decay)
        flag($sformatf("decay_rate %h, expected %h", word[31:16], want.decay));
    endtask
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // entry_index[7:0], note_pitch[15:8], note_beats[31:16], step_position[41:32], zeros
  logic [47:0]           s_tdata = '0;
  // req_type[0]
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // brightness[7:0], hue[15:8], decay_rate[31:16]
  logic [31:0]           m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  envelope_scoreboard sb = new();
  int items_sent = 0;
  int burst_left = 0;

  note_envelope_trigger #(
    .SCORE_DEPTH       (SCORE_ENTRIES),
    .UPDATE_INTERVAL_MS(UPDATE_MS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver runs its own pattern: stretches of constant readiness, coin flips,
  // sparse acceptance, and stretches of full stall, each of random length.
  int ready_mode = 0;
  int ready_run = 0;
  always @(posedge clk) begin
    if (ready_run == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_run = $urandom_range(1, 48);
    end
    ready_run--;
    case (ready_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 5) == 0);
      default: m_tready <= 1'b0;
    endcase
  end

  // Every result transaction is checked against the oldest pending envelope.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // The run ends with a failure if no transaction of any kind happens for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("note_envelope_trigger regression: fail");
    $finish;
  end

  // Sends one transaction. The sender works in bursts; between bursts valid drops for a
  // random gap, and some bursts follow the previous one with no gap at all. It is
  // called at the edge where the previous transaction was accepted, so valid stays up
  // without a glitch when no gap is taken.
  task automatic send_item(score_req_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tuser  <= req.kind;
    s_tdata  <= {6'd0, req.step, req.beats, req.pitch, req.index};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_input(req);
    items_sent++;
  endtask

  task automatic write_entry(logic [7:0] index, logic [7:0] pitch, logic [15:0] beats);
    score_req_t req;
    req = '{REQ_LOAD, index, pitch, beats, 10'sd0};
    send_item(req);
  endtask

  task automatic fire(logic signed [9:0] step);
    score_req_t req;
    req = '{REQ_TRIGGER, 8'd0, 8'd0, 16'd0, step};
    send_item(req);
  endtask

  // Holds the sender until every pending envelope has been delivered.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // A load produces no result, so a few more cycles let the last one land in the
  // score before the registers change.
  task automatic quiesce();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; the write enable drops only once.
  task automatic write_regs(logic [7:0] vol, logic [9:0] bpm, logic [8:0] len);
    logic [CFG_DATA_W-1:0] vals[3];
    logic [CFG_ADDR_W-1:0] regs[3];
    vals = '{CFG_DATA_W'(vol), bpm, CFG_DATA_W'(len)};
    regs = '{REG_VOLUME, REG_TEMPO_BPM, REG_SCORE_LENGTH};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Ties dominate so that triggers walk over chains; other negative pitches show up too.
  function automatic logic [7:0] pick_pitch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return PITCH_TIE;
    if (r < 55) return PITCH_REST;
    if (r < 90) return 8'($urandom_range(1, 127));
    return 8'($urandom_range(128, 254));
  endfunction

  function automatic logic [15:0] pick_beats();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom);
    if (r < 60) return 16'($urandom_range(0, 511));
    if (r < 70) return 16'h0000;
    if (r < 80) return 16'hFFFF;
    return 16'($urandom_range(1, 8) * 256);
  endfunction

  function automatic logic [7:0] pick_index(int len_eff);
    if (len_eff > 0 && $urandom_range(0, 99) < 85) return 8'($urandom_range(0, len_eff - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [9:0] pick_step(int len_eff);
    if (len_eff > 0 && $urandom_range(0, 99) < 80) return 10'($urandom_range(0, len_eff - 1));
    return 10'($urandom);
  endfunction

  // A note followed by a chain of ties and, now and then, an explicit end, then a
  // trigger on its head. Most chains are short; a few run long.
  task automatic write_phrase(int len_eff);
    int head;
    int ties;
    int tail;
    head = pick_index(len_eff);
    ties = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 64) : $urandom_range(0, 6);
    tail = head + ties + 1;
    write_entry(8'(head), 8'($urandom_range(1, 127)), pick_beats());
    for (int t = 1; t <= ties && head + t < SCORE_ENTRIES; t++) begin
      write_entry(8'(head + t), PITCH_TIE, pick_beats());
    end
    if (tail < SCORE_ENTRIES && $urandom_range(0, 1) == 1) begin
      write_entry(8'(tail), $urandom_range(0, 1) ? PITCH_REST : 8'($urandom_range(1, 127)),
                  pick_beats());
    end
    fire(10'(head));
  endtask

  initial begin : stimulus
    int phase;
    int len_eff;
    int n;
    int r;
    logic [7:0] vol;
    logic [9:0] bpm;
    logic [8:0] len;
    sb.reset_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With an empty score every step is out of range and reports the reset envelope.
    fire(10'sd0);
    fire(-10'sd512);
    quiesce();
    write_regs(8'd255, 10'd120, 9'd8);

    // A small score: a long note tied twice and ended by a rest, an odd negative pitch,
    // a zero-length note, a very short note whose decay saturates, a note on a sharp
    // (hue zero) at the very end of the score, and the top entry of the table.
    write_entry(8'd0, 8'd127, 16'hFFFF);
    write_entry(8'd1, PITCH_TIE, 16'hFFFF);
    write_entry(8'd2, PITCH_TIE, 16'h0100);
    write_entry(8'd3, PITCH_REST, 16'h0000);
    write_entry(8'd4, 8'h80, 16'h0000);
    write_entry(8'd5, 8'd1, 16'h0000);
    write_entry(8'd6, 8'd12, 16'h0001);
    write_entry(8'd7, 8'd61, 16'h8000);
    write_entry(8'd255, 8'd71, 16'h00FF);
    fire(10'sd0);
    fire(10'sd1);
    fire(10'sd3);
    fire(10'sd4);
    fire(10'sd5);
    fire(10'sd6);
    fire(10'sd7);
    fire(10'sd8);
    fire(10'sd511);
    fire(-10'sd1);

    // Fill the whole table so that no later trigger or tie walk reads an unwritten entry.
    for (int k = 0; k < SCORE_ENTRIES; k++) begin
      write_entry(8'(k), pick_pitch(), pick_beats());
    end

    // Random phases, each under its own register setting. The first four pin the
    // extremes: silent volume at the slowest tempo over the full table, full volume at
    // the fastest tempo with an oversized length, a zero tempo, and an empty score.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      quiesce();
      case (phase)
        0: begin
          vol = 8'd0;
          bpm = 10'd1;
          len = 9'd256;
        end
        1: begin
          vol = 8'd255;
          bpm = 10'd1023;
          len = 9'd511;
        end
        2: begin
          vol = 8'($urandom);
          bpm = 10'd0;
          len = 9'd1;
        end
        3: begin
          vol = 8'd128;
          bpm = 10'd120;
          len = 9'd0;
        end
        default: begin
          vol = 8'($urandom);
          bpm = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(40, 300)) : 10'($urandom);
          len = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 256));
        end
      endcase
      write_regs(vol, bpm, len);
      len_eff = (len > SCORE_ENTRIES) ? SCORE_ENTRIES : int'(len);
      n = $urandom_range(40, 90);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 30) write_entry(pick_index(len_eff), pick_pitch(), pick_beats());
        else if (r < 42) write_phrase(len_eff);
        else fire(pick_step(len_eff));
        if ($urandom_range(0, 99) == 0) drain();
      end
      phase++;
    end

    quiesce();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("note_envelope_trigger regression: pass");
    end else begin
      $display("note_envelope_trigger regression: fail");
    end
    $finish;
  end

endmodule
